// ===== src/u8dec_pkg.sv =====
// Shared widths, byte-class masks and the decode step result type for the UTF-8 decoder.
package u8dec_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int PEND_W = 2;

  localparam logic [BYTE_W-1:0] ASCII_MASK = 8'b0111_1111;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'b0001_1111;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'b0000_1111;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'b0000_0111;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'b0011_1111;

  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic [PEND_W-1:0] pending_next;
    logic [CP_W-1:0]   partial_next;
    logic              emit;
    logic [CP_W-1:0]   code_point;
    logic              string_end;
  } step_t;

endpackage

// ===== src/u8dec_in_if.sv =====
// Byte input channel: valid/ready handshake carrying one UTF-8 byte per transfer.
interface u8dec_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8dec_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== src/u8dec_out_if.sv =====
// Result channel: valid/ready handshake carrying one code point or end marker per transfer.
interface u8dec_out_if;
  logic                      valid;
  logic                      ready;
  logic [u8dec_pkg::CP_W-1:0] code_point;
  logic                      string_end;

  modport source (output valid, output code_point, output string_end, input ready);
  modport sink   (input valid, input code_point, input string_end, output ready);
endinterface

// ===== src/u8dec_step.sv =====
// Combinational decode of one byte against the open sequence state.
module u8dec_step (
  input  logic [u8dec_pkg::BYTE_W-1:0] in_byte,
  input  logic [u8dec_pkg::PEND_W-1:0] pending,
  input  logic [u8dec_pkg::CP_W-1:0]   partial,
  output u8dec_pkg::step_t             step
);
  import u8dec_pkg::*;

  logic [CP_W-1:0]   shifted;
  logic [BYTE_W-1:0] cont_bits;

  assign cont_bits = in_byte & CONT_MASK;
  assign shifted   = {partial[CP_W-7:0], cont_bits[5:0]};

  always_comb begin
    step.pending_next = pending;
    step.partial_next = partial;
    step.emit         = 1'b0;
    step.code_point   = '0;
    step.string_end   = 1'b0;
    priority if (in_byte == '0) begin
      step.pending_next = PEND_NONE;
      step.partial_next = '0;
      step.emit         = 1'b1;
      step.string_end   = 1'b1;
    end else if (pending != PEND_NONE) begin
      if (in_byte[7:6] != CONT_TAG) begin
        step.pending_next = PEND_NONE;
        step.partial_next = '0;
      end else if (pending == PEND_ONE) begin
        step.pending_next = PEND_NONE;
        step.partial_next = '0;
        step.emit         = 1'b1;
        step.code_point   = shifted;
      end else begin
        step.pending_next = pending - PEND_ONE;
        step.partial_next = shifted;
      end
    end else if (in_byte[7] == 1'b0) begin
      step.emit       = 1'b1;
      step.code_point = CP_W'(in_byte & ASCII_MASK);
    end else if (in_byte[7:5] == LEAD2_TAG) begin
      step.pending_next = PEND_ONE;
      step.partial_next = CP_W'(in_byte & LEAD2_MASK);
    end else if (in_byte[7:4] == LEAD3_TAG) begin
      step.pending_next = PEND_TWO;
      step.partial_next = CP_W'(in_byte & LEAD3_MASK);
    end else if (in_byte[7:3] == LEAD4_TAG) begin
      step.pending_next = PEND_THREE;
      step.partial_next = CP_W'(in_byte & LEAD4_MASK);
    end else begin
      step.pending_next = PEND_NONE;
    end
  end

endmodule

// ===== src/utf8_to_codepoint_decoder.sv =====
// UTF-8 byte stream to code point decoder, top level.
// Takes one byte per cycle and sustains one transfer per cycle on both sides while the
// result side is ready. A byte lands in an input register, is decoded against the
// open-sequence state, and any result goes to the output register. ASCII bytes and the
// final continuation byte of a 2, 3 or 4 byte sequence each give one code point; a zero
// byte gives an end marker (code_point 0, string_end 1) and drops any open sequence.
// Invalid lead bytes, stray bytes inside a sequence, and intermediate continuation bytes
// give no result. No overlong or surrogate checks.
module utf8_to_codepoint_decoder (
  input  logic         clk,
  input  logic         rst,
  u8dec_in_if.sink     text,
  u8dec_out_if.source  points
);
  import u8dec_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic [PEND_W-1:0] pending;
  logic [CP_W-1:0]   partial;
  logic              out_valid;
  logic [CP_W-1:0]   out_cp;
  logic              out_end;
  logic              advance;
  step_t             step;

  u8dec_step u_step (
    .in_byte (s1_byte),
    .pending (pending),
    .partial (partial),
    .step    (step)
  );

  assign advance           = s1_valid && (!out_valid || points.ready);
  assign text.ready        = !s1_valid || advance;
  assign points.valid      = out_valid;
  assign points.code_point = out_cp;
  assign points.string_end = out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pending   <= PEND_NONE;
      partial   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (text.ready) begin
        s1_valid <= text.valid;
      end
      if (advance) begin
        pending   <= step.pending_next;
        partial   <= step.partial_next;
        out_valid <= step.emit;
      end else if (points.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.in_byte;
    end
    if (advance) begin
      out_cp  <= step.code_point;
      out_end <= step.string_end;
    end
  end

endmodule

// ===== tb/tb_utf8_to_codepoint_decoder.sv =====
// Testbench for the UTF-8 to code point decoder: directed, random and backpressure checks.
`timescale 1ns / 1ps

module tb_utf8_to_codepoint_decoder;
  import u8dec_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            string_end;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8dec_in_if  text_ch();
  u8dec_out_if points_ch();

  utf8_to_codepoint_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .points (points_ch)
  );

  // decoder state mirror
  logic [PEND_W-1:0] seq_left;
  logic [CP_W-1:0]   seq_bits;
  point_t            point_q[$];

  int errors = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    text_ch.valid    = 1'b0;
    text_ch.in_byte  = '0;
    points_ch.ready  = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      points_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      points_ch.ready <= 1'b0;
    end else begin
      points_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && points_ch.valid && points_ch.ready) begin
      if (point_q.size() == 0) begin
        $error("unexpected transfer: code_point %0h string_end %0b",
               points_ch.code_point, points_ch.string_end);
        errors++;
      end else begin
        want = point_q.pop_front();
        if (points_ch.code_point !== want.code_point) begin
          $error("code_point: expected %0h actual %0h", want.code_point, points_ch.code_point);
          errors++;
        end
        if (points_ch.string_end !== want.string_end) begin
          $error("string_end: expected %0b actual %0b", want.string_end, points_ch.string_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (points_ch.valid && points_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    if (b == '0) begin
      seq_left = PEND_NONE;
      seq_bits = '0;
      point_q.push_back('{code_point: '0, string_end: 1'b1});
    end else if (seq_left != PEND_NONE) begin
      if (b[7:6] != CONT_TAG) begin
        seq_left = PEND_NONE;
        seq_bits = '0;
      end else begin
        seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
        seq_left = seq_left - PEND_ONE;
        if (seq_left == PEND_NONE) begin
          point_q.push_back('{code_point: seq_bits, string_end: 1'b0});
          seq_bits = '0;
        end
      end
    end else if (b[7] == 1'b0) begin
      point_q.push_back('{code_point: CP_W'(b & ASCII_MASK), string_end: 1'b0});
    end else if (b[7:5] == LEAD2_TAG) begin
      seq_bits = CP_W'(b & LEAD2_MASK);
      seq_left = PEND_ONE;
    end else if (b[7:4] == LEAD3_TAG) begin
      seq_bits = CP_W'(b & LEAD3_MASK);
      seq_left = PEND_TWO;
    end else if (b[7:3] == LEAD4_TAG) begin
      seq_bits = CP_W'(b & LEAD4_MASK);
      seq_left = PEND_THREE;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      text_ch.valid   <= 1'b0;
      text_ch.in_byte <= BYTE_W'($urandom);
      @(negedge clk);
    end
    text_ch.valid   <= 1'b1;
    text_ch.in_byte <= b;
    do @(posedge clk); while (!text_ch.ready);
    decode_byte(b);
    @(negedge clk);
  endtask

  // sends the first nbytes of the len-byte encoding of cp
  task automatic send_seq(input int len, input logic [CP_W-1:0] cp, input int nbytes);
    logic [BYTE_W-1:0] b;
    for (int k = 0; k < nbytes; k++) begin
      if (k == 0) begin
        case (len)
          2: b = {LEAD2_TAG, cp[10:6]};
          3: b = {LEAD3_TAG, cp[15:12]};
          default: b = {LEAD4_TAG, cp[20:18]};
        endcase
      end else begin
        b = {CONT_TAG, cp[6*(len-1-k) +: 6]};
      end
      send_byte(b);
    end
  endtask

  task automatic wait_drain();
    text_ch.valid <= 1'b0;
    while (point_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [BYTE_W-1:0] bytes[$];
    bytes = '{8'h01, 8'h7F,
              8'hC2, 8'hA9,
              8'hC0, 8'h80,
              8'hE2, 8'h82, 8'hAC,
              8'hF7, 8'hBF, 8'hBF, 8'hBF,
              8'h80, 8'hBF, 8'hF8, 8'hFF,
              8'hE2, 8'h41,
              8'hC2, 8'hE2,
              8'hF0, 8'h9F, 8'h00,
              8'h00};
    foreach (bytes[i]) send_byte(bytes[i]);
    wait_drain();
  endtask

  task automatic send_random_run(input int n_items);
    int done;
    int pick;
    int len;
    int cut;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      len  = $urandom_range(4, 2);
      if (pick < 30) begin
        send_byte(BYTE_W'($urandom_range(127, 1)));
        done++;
      end else if (pick < 75) begin
        send_seq(len, CP_W'($urandom), len);
        done += len;
      end else if (pick < 85) begin
        cut = $urandom_range(len - 1, 1);
        send_seq(len, CP_W'($urandom), cut);
        done += cut;
      end else if (pick < 95) begin
        send_byte(BYTE_W'($urandom));
      end else begin
        send_byte('0);
        done++;
      end
    end
  endtask

  task automatic test_random_traffic();
    send_gap_pct = 0;  recv_stall_pct = 0;  send_random_run(250);
    send_gap_pct = 66; recv_stall_pct = 0;  send_random_run(250);
    send_gap_pct = 0;  recv_stall_pct = 66; send_random_run(250);
    send_gap_pct = 22; recv_stall_pct = 22; send_random_run(250);
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 40; i++) send_byte(BYTE_W'($urandom_range(127, 1)));
    wait_drain();
    send_seq(4, CP_W'($urandom), 4);
    send_byte('0);
    wait_drain();
  endtask

  initial begin
    seq_left = PEND_NONE;
    seq_bits = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random_traffic();
    repeat (8) @(negedge clk);
    if (point_q.size() != 0) begin
      $error("%0d expected results never arrived", point_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== utf8_to_codepoint_decoder.f =====
src/u8dec_pkg.sv
src/u8dec_in_if.sv
src/u8dec_out_if.sv
src/u8dec_step.sv
src/utf8_to_codepoint_decoder.sv
tb/tb_utf8_to_codepoint_decoder.sv
